### rtl/core/fprb_pkg.sv
// Shared types and constants for the framed packet ring buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
package fprb_pkg;

    localparam int BUFFER_BYTES_DEF = 2048;
    localparam int LEN_BYTES        = 4;
    localparam int STAMP_BYTES      = 8;
    localparam int HDR_BYTES        = LEN_BYTES + STAMP_BYTES;
    localparam int CNT_W            = $clog2(HDR_BYTES);
    localparam int LEN_W            = 12;

    typedef enum logic [1:0] {
        OP_BEGIN_WRITE = 2'd0,
        OP_WRITE_BYTE  = 2'd1,
        OP_BEGIN_READ  = 2'd2,
        OP_READ_BYTE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_NO_READ  = 3'd4,
        ST_NO_WRITE = 3'd5
    } t_status;

    typedef struct packed {
        t_op         operation;
        logic [10:0] payload_length;
        logic [62:0] time_stamp;
        logic [7:0]  data_in;
        logic [11:0] read_limit;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  data_out;
        logic [10:0] packet_length;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_BW_START,
        DP_HDR_BYTE,
        DP_WR_BYTE,
        DP_OPEN_REPEAT,
        DP_RH_START,
        DP_RH_STEP,
        DP_RH_CAPTURE,
        DP_RH_CHECK,
        DP_RB_START,
        DP_RB_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    load_res;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic wr_open;
        logic wr_fits;
        logic rd_open;
        logic empty;
        logic res_busy;
    } t_dp_stat;

endpackage

### rtl/core/fprb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module fprb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fprb_ctrl.sv
// Controller state machine of the framed packet ring buffer.
// Sequences header walks and byte reads; depends on fprb_pkg.
module fprb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  fprb_pkg::t_op      i_op,
    input  fprb_pkg::t_dp_stat i_stat,
    output logic               o_in_stall,
    output fprb_pkg::t_dp_cmd  o_cmd
);

    localparam int CW = fprb_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR_WR,
        S_HDR_RD,
        S_CHECK,
        S_BYTE_RD
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    logic              accept;
    fprb_pkg::t_dp_cmd cmd;

    assign o_in_stall = (r_state != S_IDLE) || i_stat.res_busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cmd      = cmd;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        cmd.op       = fprb_pkg::DP_NONE;
        cmd.load_res = 1'b0;
        cmd.status   = fprb_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        fprb_pkg::OP_BEGIN_WRITE: begin
                            if (i_stat.wr_open || !i_stat.wr_fits) begin
                                cmd.load_res = 1'b1;
                                cmd.status   = fprb_pkg::ST_NO_SPACE;
                            end else begin
                                cmd.op  = fprb_pkg::DP_BW_START;
                                n_state = S_HDR_WR;
                                n_cnt   = '0;
                            end
                        end
                        fprb_pkg::OP_WRITE_BYTE: begin
                            cmd.load_res = 1'b1;
                            if (!i_stat.wr_open) begin
                                cmd.status = fprb_pkg::ST_NO_WRITE;
                            end else begin
                                cmd.op = fprb_pkg::DP_WR_BYTE;
                            end
                        end
                        fprb_pkg::OP_BEGIN_READ: begin
                            if (i_stat.rd_open) begin
                                cmd.op       = fprb_pkg::DP_OPEN_REPEAT;
                                cmd.load_res = 1'b1;
                            end else if (i_stat.empty) begin
                                cmd.load_res = 1'b1;
                                cmd.status   = fprb_pkg::ST_EMPTY;
                            end else begin
                                cmd.op  = fprb_pkg::DP_RH_START;
                                n_state = S_HDR_RD;
                                n_cnt   = '0;
                            end
                        end
                        fprb_pkg::OP_READ_BYTE: begin
                            if (!i_stat.rd_open) begin
                                cmd.load_res = 1'b1;
                                cmd.status   = fprb_pkg::ST_NO_READ;
                            end else begin
                                cmd.op  = fprb_pkg::DP_RB_START;
                                n_state = S_BYTE_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_HDR_WR: begin
                cmd.op = fprb_pkg::DP_HDR_BYTE;
                if (r_cnt == CW'(fprb_pkg::HDR_BYTES - 1)) begin
                    cmd.load_res = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_HDR_RD: begin
                if (r_cnt == CW'(fprb_pkg::LEN_BYTES - 1)) begin
                    cmd.op  = fprb_pkg::DP_RH_CAPTURE;
                    n_state = S_CHECK;
                end else begin
                    cmd.op = fprb_pkg::DP_RH_STEP;
                    n_cnt  = r_cnt + CW'(1);
                end
            end
            S_CHECK: begin
                cmd.op       = fprb_pkg::DP_RH_CHECK;
                cmd.load_res = 1'b1;
                n_state      = S_IDLE;
            end
            S_BYTE_RD: begin
                cmd.op       = fprb_pkg::DP_RB_OUT;
                cmd.load_res = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### rtl/core/fprb_datapath.sv
// Datapath of the framed packet ring buffer: pointers, space counters,
// header registers, the byte store and the result register.
// Depends on fprb_pkg and fprb_ram.
module fprb_datapath #(
    parameter int BUFFER_BYTES = fprb_pkg::BUFFER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fprb_pkg::t_in_item  i_item,
    input  fprb_pkg::t_dp_cmd   i_cmd,
    input  logic                i_out_stall,
    output fprb_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    output fprb_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = fprb_pkg::LEN_W;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        next_ptr = (p == AW'(BUFFER_BYTES - 1)) ? '0 : p + AW'(1);
    endfunction

    logic [AW-1:0]       r_wp, n_wp;
    logic [AW-1:0]       r_rp, n_rp;
    logic [AW-1:0]       r_scan, n_scan;
    logic [CW-1:0]       r_free, n_free;
    logic [CW-1:0]       r_used, n_used;
    logic [CW-1:0]       r_open, n_open;
    logic [10:0]         r_wr_rem, n_wr_rem;
    logic [LW-1:0]       r_rd_rem, n_rd_rem;
    logic [LW-1:0]       r_rd_len, n_rd_len;
    logic                r_last_pend, n_last_pend;
    logic [95:0]         r_hdr, n_hdr;
    logic [31:0]         r_len, n_len;
    logic [11:0]         r_limit, n_limit;
    logic                r_res_valid, n_res_valid;
    fprb_pkg::t_out_item r_res, n_res;

    logic                mem_we;
    logic [7:0]          mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [7:0]          rd_data;
    logic [CW-1:0]       need;
    logic [CW-1:0]       rd_size;
    logic                len_bad;

    fprb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    assign need    = CW'(32'(i_item.payload_length) + 32'(fprb_pkg::HDR_BYTES));
    assign rd_size = CW'(32'(r_rd_len) + 32'(fprb_pkg::LEN_BYTES));
    assign len_bad = (r_used < CW'(fprb_pkg::LEN_BYTES))
                  || (r_len > 32'(r_used) - 32'(fprb_pkg::LEN_BYTES))
                  || (r_len > 32'(r_limit));

    assign o_stat.wr_open  = (r_wr_rem != '0);
    assign o_stat.wr_fits  = 32'(r_free) >= 32'(i_item.payload_length)
                                            + 32'(fprb_pkg::HDR_BYTES);
    assign o_stat.rd_open  = (r_rd_rem != '0);
    assign o_stat.empty    = (r_used == '0);
    assign o_stat.res_busy = r_res_valid && i_out_stall;

    assign mem_we    = (i_cmd.op == fprb_pkg::DP_HDR_BYTE) || (i_cmd.op == fprb_pkg::DP_WR_BYTE);
    assign mem_wdata = (i_cmd.op == fprb_pkg::DP_HDR_BYTE) ? r_hdr[7:0] : i_item.data_in;
    assign mem_raddr = (i_cmd.op == fprb_pkg::DP_RH_STEP) ? r_scan : r_rp;

    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_scan      = r_scan;
        n_free      = r_free;
        n_used      = r_used;
        n_open      = r_open;
        n_wr_rem    = r_wr_rem;
        n_rd_rem    = r_rd_rem;
        n_rd_len    = r_rd_len;
        n_last_pend = r_last_pend;
        n_hdr       = r_hdr;
        n_len       = r_len;
        n_limit     = r_limit;
        unique case (i_cmd.op) inside
            fprb_pkg::DP_BW_START: begin
                n_hdr  = {1'b0, i_item.time_stamp,
                          32'(i_item.payload_length) + 32'(fprb_pkg::STAMP_BYTES)};
                n_free = r_free - need;
                if (i_item.payload_length == '0) begin
                    n_used = r_used + need;
                    n_open = '0;
                end else begin
                    n_wr_rem = i_item.payload_length;
                    n_open   = need;
                end
            end
            fprb_pkg::DP_HDR_BYTE: begin
                n_wp  = next_ptr(r_wp);
                n_hdr = {8'h00, r_hdr[95:8]};
            end
            fprb_pkg::DP_WR_BYTE: begin
                n_wp     = next_ptr(r_wp);
                n_wr_rem = r_wr_rem - 11'd1;
                if (r_wr_rem == 11'd1) begin
                    n_used = r_used + r_open;
                    n_open = '0;
                end
            end
            fprb_pkg::DP_RH_START: begin
                n_scan  = next_ptr(r_rp);
                n_limit = i_item.read_limit;
            end
            fprb_pkg::DP_RH_STEP: begin
                n_scan = next_ptr(r_scan);
                n_len  = {rd_data, r_len[31:8]};
            end
            fprb_pkg::DP_RH_CAPTURE: begin
                n_len = {rd_data, r_len[31:8]};
            end
            fprb_pkg::DP_RH_CHECK: begin
                if (len_bad) begin
                    n_rp     = r_wp;
                    n_free   = CW'(BUFFER_BYTES);
                    n_used   = '0;
                    n_wr_rem = '0;
                    n_open   = '0;
                    n_rd_len = '0;
                end else begin
                    n_rp = r_scan;
                    if (r_len == 32'd0) begin
                        n_used   = r_used - CW'(fprb_pkg::LEN_BYTES);
                        n_free   = r_free + CW'(fprb_pkg::LEN_BYTES);
                        n_rd_len = '0;
                    end else begin
                        n_rd_rem = LW'(r_len);
                        n_rd_len = LW'(r_len);
                    end
                end
            end
            fprb_pkg::DP_RB_START: begin
                n_rp        = next_ptr(r_rp);
                n_rd_rem    = r_rd_rem - LW'(1);
                n_last_pend = (r_rd_rem == LW'(1));
                if (r_rd_rem == LW'(1)) begin
                    n_used   = r_used - rd_size;
                    n_free   = r_free + rd_size;
                    n_rd_len = '0;
                end
            end
            fprb_pkg::DP_NONE, fprb_pkg::DP_OPEN_REPEAT, fprb_pkg::DP_RB_OUT: begin
                n_wp = r_wp;
            end
            default: begin
                n_wp = r_wp;
            end
        endcase
    end

    always_comb begin
        n_res_valid = r_res_valid && i_out_stall;
        n_res       = r_res;
        if (i_cmd.load_res) begin
            n_res_valid         = 1'b1;
            n_res.status        = i_cmd.status;
            n_res.data_out      = '0;
            n_res.packet_length = '0;
            n_res.last          = 1'b0;
            if (i_cmd.op == fprb_pkg::DP_RH_CHECK) begin
                if (len_bad) begin
                    n_res.status = fprb_pkg::ST_BAD_LEN;
                end else begin
                    n_res.packet_length = r_len[10:0];
                end
            end else if (i_cmd.op == fprb_pkg::DP_OPEN_REPEAT) begin
                n_res.packet_length = r_rd_len[10:0];
            end else if (i_cmd.op == fprb_pkg::DP_RB_OUT) begin
                n_res.data_out = rd_data;
                n_res.last     = r_last_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_free      <= CW'(BUFFER_BYTES);
            r_used      <= '0;
            r_open      <= '0;
            r_wr_rem    <= '0;
            r_rd_rem    <= '0;
            r_rd_len    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_free      <= n_free;
            r_used      <= n_used;
            r_open      <= n_open;
            r_wr_rem    <= n_wr_rem;
            r_rd_rem    <= n_rd_rem;
            r_rd_len    <= n_rd_len;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan      <= n_scan;
        r_last_pend <= n_last_pend;
        r_hdr       <= n_hdr;
        r_len       <= n_len;
        r_limit     <= n_limit;
        r_res       <= n_res;
    end

    assign o_out_valid = r_res_valid;
    assign o_out_item  = r_res;

endmodule

### rtl/core/framed_packet_ring_buffer.sv
// Framed packet ring buffer. A payload byte write, or any refused operation, gives its
// result in the cycle after it is taken, and such items can follow one per cycle while the
// output is not stalled. A byte read goes through a registered store read, a begin read
// reads four header bytes through the single store port, then runs the length check,
// and a begin write writes twelve header bytes, one per cycle.
// Reset is synchronous; the store itself is not cleared.
module framed_packet_ring_buffer #(
    parameter int BUFFER_BYTES = fprb_pkg::BUFFER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fprb_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fprb_pkg::t_out_item o_out_item
);

    fprb_pkg::t_dp_cmd  cmd;
    fprb_pkg::t_dp_stat stat;

    fprb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_item.operation),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    fprb_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_out_valid || o_in_stall))
        else $error("accepted item neither produced a result nor held the input");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_res |=> o_out_valid)
        else $error("result load did not raise the output valid");

    a_write_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == fprb_pkg::DP_WR_BYTE) |-> stat.wr_open)
        else $error("payload byte stored with no write open");

    a_read_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == fprb_pkg::DP_RB_START) |-> stat.rd_open)
        else $error("byte read started with no read open");

endmodule

### tb/tb_framed_packet_ring_buffer.sv
// Self-checking testbench for the framed packet ring buffer: directed cases, a full store,
// a long output hold-off and random packet traffic, each result checked against a predictor.
// Depends on fprb_pkg and the framed_packet_ring_buffer RTL.
module tb_framed_packet_ring_buffer;

    localparam int RING_BYTES     = fprb_pkg::BUFFER_BYTES_DEF;
    localparam int RING_AW        = $clog2(RING_BYTES);
    localparam int MAX_WAIT       = 19;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1200;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    fprb_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    fprb_pkg::t_out_item o_out_item;

    framed_packet_ring_buffer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted contents and bookkeeping of the ring.
    logic [7:0]         store_img [RING_BYTES];
    logic [RING_AW-1:0] wr_idx;
    logic [RING_AW-1:0] rd_idx;
    int                 free_cnt;
    int                 used_cnt;
    int                 wr_left;
    int                 rd_left;
    int                 wr_size;
    int                 rd_size;

    fprb_pkg::t_out_item awaited_replies[$];
    fprb_pkg::t_out_item oldest_reply;
    int                  mismatches = 0;
    logic                idle_on = 1'b1;
    logic                hold_req = 1'b0;
    int                  held_cycles = 0;
    int                  stall_left = 0;
    int                  out_gap;
    int                  quiet_cycles = 0;

    function automatic void ring_reset();
        foreach (store_img[k]) store_img[k] = 8'd0;
        wr_idx   = '0;
        rd_idx   = '0;
        free_cnt = RING_BYTES;
        used_cnt = 0;
        wr_left  = 0;
        rd_left  = 0;
        wr_size  = 0;
        rd_size  = 0;
    endfunction

    function automatic fprb_pkg::t_out_item predict_ring_reply(fprb_pkg::t_in_item it);
        fprb_pkg::t_out_item r;
        int                  need;
        int                  len;
        int                  i;
        logic [RING_AW-1:0]  p;
        r = '{fprb_pkg::ST_OK, 8'd0, 11'd0, 1'b0};
        case (it.operation)
            fprb_pkg::OP_BEGIN_WRITE: begin
                need = int'(it.payload_length) + fprb_pkg::HDR_BYTES;
                if (wr_left != 0 || free_cnt < need) begin
                    r.status = fprb_pkg::ST_NO_SPACE;
                end else begin
                    len = int'(it.payload_length) + fprb_pkg::STAMP_BYTES;
                    for (i = 0; i < fprb_pkg::LEN_BYTES; i++) begin
                        store_img[wr_idx] = 8'(len >> (8 * i));
                        wr_idx++;
                    end
                    for (i = 0; i < fprb_pkg::STAMP_BYTES; i++) begin
                        store_img[wr_idx] = 8'(it.time_stamp >> (8 * i));
                        wr_idx++;
                    end
                    free_cnt -= need;
                    if (it.payload_length == 0) begin
                        used_cnt += need;
                        wr_size = 0;
                    end else begin
                        wr_left = int'(it.payload_length);
                        wr_size = need;
                    end
                end
            end
            fprb_pkg::OP_WRITE_BYTE: begin
                if (wr_left == 0) begin
                    r.status = fprb_pkg::ST_NO_WRITE;
                end else begin
                    store_img[wr_idx] = it.data_in;
                    wr_idx++;
                    wr_left--;
                    if (wr_left == 0) begin
                        used_cnt += wr_size;
                        wr_size = 0;
                    end
                end
            end
            fprb_pkg::OP_BEGIN_READ: begin
                if (rd_left != 0) begin
                    r.packet_length = 11'(rd_size - fprb_pkg::LEN_BYTES);
                end else if (used_cnt == 0) begin
                    r.status = fprb_pkg::ST_EMPTY;
                end else begin
                    len = 0;
                    p = rd_idx;
                    for (i = 0; i < fprb_pkg::LEN_BYTES; i++) begin
                        len |= int'(store_img[p]) << (8 * i);
                        p++;
                    end
                    if (used_cnt < fprb_pkg::LEN_BYTES
                            || len > used_cnt - fprb_pkg::LEN_BYTES
                            || len > int'(it.read_limit)) begin
                        r.status = fprb_pkg::ST_BAD_LEN;
                        rd_idx   = wr_idx;
                        free_cnt = RING_BYTES;
                        used_cnt = 0;
                        wr_left  = 0;
                        wr_size  = 0;
                        rd_size  = 0;
                    end else begin
                        rd_idx = p;
                        r.packet_length = 11'(len);
                        if (len == 0) begin
                            used_cnt -= fprb_pkg::LEN_BYTES;
                            free_cnt += fprb_pkg::LEN_BYTES;
                            rd_size = 0;
                        end else begin
                            rd_left = len;
                            rd_size = len + fprb_pkg::LEN_BYTES;
                        end
                    end
                end
            end
            default: begin
                if (rd_left == 0) begin
                    r.status = fprb_pkg::ST_NO_READ;
                end else begin
                    r.data_out = store_img[rd_idx];
                    rd_idx++;
                    rd_left--;
                    if (rd_left == 0) begin
                        r.last = 1'b1;
                        used_cnt -= rd_size;
                        free_cnt += rd_size;
                        rd_size = 0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [62:0] random_stamp();
        return 63'({$urandom, $urandom});
    endfunction

    function automatic fprb_pkg::t_in_item build_item(fprb_pkg::t_op op, int plen,
                                                      logic [62:0] stamp, int data,
                                                      int limit);
        fprb_pkg::t_in_item it;
        it.operation      = op;
        it.payload_length = 11'(plen);
        it.time_stamp     = stamp;
        it.data_in        = 8'(data);
        it.read_limit     = 12'(limit);
        return it;
    endfunction

    function automatic fprb_pkg::t_in_item noise_item();
        fprb_pkg::t_in_item it;
        it = build_item(fprb_pkg::t_op'($urandom_range(0, 3)), $urandom_range(0, 2047),
                        random_stamp(), $urandom_range(0, 255), $urandom_range(0, 4095));
        if (it.operation == fprb_pkg::OP_BEGIN_WRITE && wr_left == 0) begin
            it.payload_length[10:5] = '0;
        end
        return it;
    endfunction

    task automatic send_item(input fprb_pkg::t_in_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        awaited_replies.push_back(predict_ring_reply(it));
    endtask

    task automatic write_packet(input int plen);
        send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, plen, random_stamp(), 0, 0));
        while (wr_left != 0) begin
            send_item(build_item(fprb_pkg::OP_WRITE_BYTE, 0, 63'd0, $urandom_range(0, 255),
                                 0));
        end
    endtask

    task automatic read_packet(input int limit);
        send_item(build_item(fprb_pkg::OP_BEGIN_READ, 0, 63'd0, 0, limit));
        while (rd_left != 0) begin
            send_item(build_item(fprb_pkg::OP_READ_BYTE, 0, 63'd0, 0, 0));
        end
    endtask

    task automatic test_directed_cases();
        logic [62:0] stamp_max;
        stamp_max = '1;
        idle_on <= 1'b1;
        send_item(build_item(fprb_pkg::OP_READ_BYTE, 0, 63'd0, 0, 0));
        send_item(build_item(fprb_pkg::OP_WRITE_BYTE, 0, 63'd0, 255, 0));
        send_item(build_item(fprb_pkg::OP_BEGIN_READ, 0, 63'd0, 0, 4095));
        send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, 2047, stamp_max, 0, 0));
        send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, 0, stamp_max, 0, 0));
        send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, 2036, stamp_max, 0, 0));
        send_item(build_item(fprb_pkg::OP_BEGIN_READ, 0, 63'd0, 0, 7));
        send_item(build_item(fprb_pkg::OP_BEGIN_READ, 0, 63'd0, 0, 4095));
        send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, 0, 63'd0, 0, 0));
        send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, 2, random_stamp(), 0, 0));
        send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, 1, random_stamp(), 0, 0));
        send_item(build_item(fprb_pkg::OP_WRITE_BYTE, 0, 63'd0, 0, 0));
        // A failed length check also drops the write that is still open.
        send_item(build_item(fprb_pkg::OP_BEGIN_READ, 0, 63'd0, 0, 0));
        send_item(build_item(fprb_pkg::OP_WRITE_BYTE, 0, 63'd0, 255, 0));
        send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, 0, stamp_max, 0, 0));
        send_item(build_item(fprb_pkg::OP_BEGIN_READ, 0, 63'd0, 0, 8));
        send_item(build_item(fprb_pkg::OP_BEGIN_READ, 0, 63'd0, 0, 0));
        repeat (9) send_item(build_item(fprb_pkg::OP_READ_BYTE, 0, 63'd0, 0, 0));
        send_item(build_item(fprb_pkg::OP_BEGIN_READ, 0, 63'd0, 0, 4095));
    endtask

    task automatic test_full_store();
        idle_on <= 1'b1;
        while (free_cnt >= fprb_pkg::HDR_BYTES) begin
            send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, 0, random_stamp(), 0, 0));
        end
        send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, 0, random_stamp(), 0, 0));
        read_packet(RING_BYTES - fprb_pkg::LEN_BYTES);
        send_item(build_item(fprb_pkg::OP_BEGIN_READ, 0, 63'd0, 0, 0));
    endtask

    task automatic test_output_hold();
        idle_on  <= 1'b0;
        hold_req <= 1'b1;
        repeat (4) begin
            write_packet($urandom_range(1, 30));
            read_packet(4095);
        end
        i_in_valid <= 1'b0;
        while (held_cycles < LONG_HOLD) @(posedge i_clk);
        hold_req <= 1'b0;
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int pick;
        int sub;
        int plen;
        int limit;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 200 == 0) begin
                idle_on <= ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            sub  = $urandom_range(0, 49);
            if (pick < 6) begin
                send_item(noise_item());
            end else if (wr_left != 0) begin
                if (pick < 8) begin
                    send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, $urandom_range(0, 40),
                                         random_stamp(), 0, 0));
                end else begin
                    send_item(build_item(fprb_pkg::OP_WRITE_BYTE, 0, 63'd0,
                                         $urandom_range(0, 255), 0));
                end
            end else if (rd_left != 0) begin
                send_item(build_item(fprb_pkg::OP_READ_BYTE, 0, 63'd0, 0, 0));
            end else if (used_cnt != 0 && (pick < 55 || free_cnt < 64)) begin
                if (sub < 3) begin
                    limit = $urandom_range(0, 4095);
                end else if (sub < 6) begin
                    limit = $urandom_range(0, 40);
                end else begin
                    limit = $urandom_range(RING_BYTES - fprb_pkg::LEN_BYTES, 4095);
                end
                send_item(build_item(fprb_pkg::OP_BEGIN_READ, 0, 63'd0, 0, limit));
            end else begin
                if (sub == 0) begin
                    plen = $urandom_range(0, 2047);
                end else if (sub < 5) begin
                    plen = 0;
                end else begin
                    plen = $urandom_range(1, 24);
                end
                send_item(build_item(fprb_pkg::OP_BEGIN_WRITE, plen, random_stamp(), 0, 0));
            end
            sent++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!hold_req) begin
            held_cycles <= 0;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (hold_req && held_cycles < LONG_HOLD) begin
            i_out_stall <= 1'b1;
            held_cycles <= held_cycles + 1;
        end else if (o_out_valid && !i_out_stall) begin
            out_gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            i_out_stall <= (out_gap != 0);
            stall_left  <= (out_gap == 0) ? 0 : out_gap - 1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_replies.size() == 0) begin
                $error("unexpected result: status %0d", o_out_item.status);
                mismatches++;
            end else begin
                oldest_reply = awaited_replies.pop_front();
                if (o_out_item.status !== oldest_reply.status) begin
                    $error("status: expected %0d, got %0d", oldest_reply.status,
                           o_out_item.status);
                    mismatches++;
                end
                if (o_out_item.data_out !== oldest_reply.data_out) begin
                    $error("data_out: expected %0d, got %0d", oldest_reply.data_out,
                           o_out_item.data_out);
                    mismatches++;
                end
                if (o_out_item.packet_length !== oldest_reply.packet_length) begin
                    $error("packet_length: expected %0d, got %0d", oldest_reply.packet_length,
                           o_out_item.packet_length);
                    mismatches++;
                end
                if (o_out_item.last !== oldest_reply.last) begin
                    $error("last: expected %0d, got %0d", oldest_reply.last, o_out_item.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_framed_packet_ring_buffer failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        ring_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_full_store();
        test_output_hold();
        test_random_traffic(RANDOM_ITEMS);
        i_in_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_framed_packet_ring_buffer passed");
        end else begin
            $display("tb_framed_packet_ring_buffer failed");
        end
        $finish;
    end
endmodule

### sim.f
rtl/core/fprb_pkg.sv
rtl/core/fprb_ram.sv
rtl/core/fprb_ctrl.sv
rtl/core/fprb_datapath.sv
rtl/core/framed_packet_ring_buffer.sv
tb/tb_framed_packet_ring_buffer.sv
